### hdl/pfe_pkg.sv
// shared constants, character codes and alu request types for the postfix evaluator
package pfe_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TOK_W       = 8;
  localparam int unsigned DEPTH_OUT_W = 5;

  // character codes
  localparam logic [TOK_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [TOK_W-1:0] CH_MINUS = 8'd45;
  localparam logic [TOK_W-1:0] CH_STAR  = 8'd42;
  localparam logic [TOK_W-1:0] CH_SLASH = 8'd47;
  localparam logic [TOK_W-1:0] CH_CARET = 8'd94;
  localparam logic [TOK_W-1:0] CH_LPAR  = 8'd40;
  localparam logic [TOK_W-1:0] CH_RPAR  = 8'd41;
  localparam logic [TOK_W-1:0] CH_ZERO  = 8'd48;

  // one iteration per bit for multiply and divide
  localparam int unsigned ALU_STEPS = DATA_W;
  localparam int unsigned STEP_W    = $clog2(ALU_STEPS);

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

### hdl/postfix_expression_evaluator_core.sv
// top level of the postfix evaluator: token sequencer, value stack and result register
//
// usage
//   input channel: token_i and last_token_i, taken at an edge where in_valid_i is high
//   and in_stall_o is low. one request is worked on at a time; in_stall_o goes high
//   at the accepting edge and stays high until the result is committed.
//   output channel: one result per token (top_value_o, stack_depth_o and the flags),
//   held in an output register until taken with out_valid_o high and out_stall_i low.
//   a finished result may wait there while the next token is already being accepted.
// steps, accept to next accept
//   operand or bad operator: decode, done. add, subtract, multiply: decode, alu wait, done.
//   divide: decode, alu wait (sign removal, one quotient bit per cycle, sign fix), done.
//   the shared alu iterates one bit per cycle for multiply and divide.
//   the result shows on out_valid_o as in_stall_o drops for the next token.
// stalls
//   if the output register is still full when a result is ready, the sequencer
//   holds it and keeps in_stall_o high until the register frees up.
// reset
//   rst_ni low empties the stack (depth 0) and drops out_valid_o. stack entries are
//   never read before being written, so the stack ram needs no clearing pass.
module postfix_expression_evaluator_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [pfe_pkg::TOK_W-1:0]              token_i,
  input  logic                                   last_token_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pfe_pkg::DATA_W-1:0]      top_value_o,
  output logic [pfe_pkg::DEPTH_OUT_W-1:0]        stack_depth_o,
  output logic                                   underflow_o,
  output logic                                   overflow_o,
  output logic                                   div_by_zero_o,
  output logic                                   bad_operator_o,
  output logic                                   expression_end_o
);

  localparam int unsigned W     = pfe_pkg::DATA_W;
  localparam int unsigned CNT_W = pfe_pkg::CNT_W;
  localparam int unsigned PTR_W = pfe_pkg::PTR_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [pfe_pkg::TOK_W-1:0]   tok_q;
  logic                        last_q;
  logic                        is_op_q, is_op_d;
  logic                        push_q, push_d;
  logic [W-1:0]                res_q, res_d;
  logic                        under_q, under_d;
  logic                        over_q, over_d;
  logic                        dz_q, dz_d;
  logic                        bad_q, bad_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [W-1:0]                top_q, top_d;

  // output register
  logic                              out_valid_q, out_valid_d;
  logic [W-1:0]                      out_top_q;
  logic [pfe_pkg::DEPTH_OUT_W-1:0]   out_depth_q;
  logic                              out_under_q, out_over_q, out_dz_q, out_bad_q, out_end_q;

  // stack ram and alu hookup
  logic                        ram_we;
  logic [PTR_W-1:0]            ram_waddr, ram_raddr;
  logic [W-1:0]                ram_rdata;
  pfe_pkg::alu_req_t           alu_req;
  pfe_pkg::alu_rsp_t           alu_rsp;
  logic [W-1:0]                alu_result;

  // decode helpers
  logic                        accept;
  logic                        tok_is_op, tok_is_bad, tok_is_arith;
  logic                        has_two, has_one, full;
  logic [W-1:0]                left_val, right_val;
  logic                        slot_free, commit;
  logic [CNT_W-1:0]            count_after;
  logic [W-1:0]                top_after;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // the value below the top sits at count - 2; the top itself is cached in top_q
  assign ram_raddr = PTR_W'(count_q - CNT_W'(2));

  assign has_two = (count_q >= CNT_W'(2));
  assign has_one = (count_q != '0);
  assign full    = (count_q == CNT_W'(pfe_pkg::STACK_DEPTH));

  assign left_val  = has_two ? ram_rdata : '0;
  assign right_val = has_one ? top_q : '0;

  // token classes and the alu request
  always_comb begin
    tok_is_arith = 1'b0;
    tok_is_bad   = 1'b0;
    alu_req.op   = pfe_pkg::ALU_DIV;
    unique case (tok_q) inside
      pfe_pkg::CH_PLUS: begin
        tok_is_arith = 1'b1;
        alu_req.op   = pfe_pkg::ALU_ADD;
      end
      pfe_pkg::CH_MINUS: begin
        tok_is_arith = 1'b1;
        alu_req.op   = pfe_pkg::ALU_SUB;
      end
      pfe_pkg::CH_STAR: begin
        tok_is_arith = 1'b1;
        alu_req.op   = pfe_pkg::ALU_MUL;
      end
      pfe_pkg::CH_SLASH: begin
        tok_is_arith = 1'b1;
        alu_req.op   = pfe_pkg::ALU_DIV;
      end
      pfe_pkg::CH_CARET, pfe_pkg::CH_LPAR, pfe_pkg::CH_RPAR: begin
        tok_is_bad = 1'b1;
      end
      default: ;
    endcase
    alu_req.start = (state_q == S_DECODE) && tok_is_arith;
  end

  assign tok_is_op = tok_is_arith || tok_is_bad;

  // commit happens once the output register can take the result
  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == S_DONE) && slot_free;

  // operators push where the left operand was (or at the bottom after underflow)
  always_comb begin
    if (is_op_q) begin
      ram_waddr = has_two ? PTR_W'(count_q - CNT_W'(2)) : '0;
    end else begin
      ram_waddr = PTR_W'(count_q);
    end
    count_after = push_q ? (CNT_W'(ram_waddr) + CNT_W'(1)) : count_q;
    top_after   = push_q ? res_q : top_q;
  end

  assign ram_we = commit && push_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    is_op_d = is_op_q;
    push_d  = push_q;
    res_d   = res_q;
    under_d = under_q;
    over_d  = over_q;
    dz_d    = dz_q;
    bad_d   = bad_q;
    count_d = count_q;
    top_d   = top_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        is_op_d = tok_is_op;
        dz_d    = 1'b0;
        bad_d   = tok_is_bad;
        if (tok_is_op) begin
          // both pops may come up empty
          under_d = !has_two;
          over_d  = 1'b0;
          push_d  = 1'b1;
          res_d   = '0;
          state_d = tok_is_arith ? S_WAIT : S_DONE;
        end else begin
          under_d = 1'b0;
          over_d  = full;
          push_d  = !full;
          res_d   = W'(tok_q) - W'(pfe_pkg::CH_ZERO);
          state_d = S_DONE;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          res_d   = alu_result;
          dz_d    = alu_rsp.div_zero;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          top_d   = top_after;
          count_d = last_q ? '0 : count_after;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = commit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q  <= token_i;
      last_q <= last_token_i;
    end
    is_op_q <= is_op_d;
    push_q  <= push_d;
    res_q   <= res_d;
    under_q <= under_d;
    over_q  <= over_d;
    dz_q    <= dz_d;
    bad_q   <= bad_d;
    top_q   <= top_d;
    if (commit) begin
      // the report shows the stack before an end-of-expression clear
      out_top_q   <= (count_after == '0) ? '0 : top_after;
      out_depth_q <= pfe_pkg::DEPTH_OUT_W'(count_after);
      out_under_q <= under_q;
      out_over_q  <= over_q;
      out_dz_q    <= dz_q;
      out_bad_q   <= bad_q;
      out_end_q   <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign top_value_o      = out_top_q;
  assign stack_depth_o    = out_depth_q;
  assign underflow_o      = out_under_q;
  assign overflow_o       = out_over_q;
  assign div_by_zero_o    = out_dz_q;
  assign bad_operator_o   = out_bad_q;
  assign expression_end_o = out_end_q;

  pfe_ram #(
    .WIDTH (W),
    .DEPTH (pfe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (res_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfe_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (left_val),
    .b_i      (right_val),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  // stack count never runs past the ram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(pfe_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // an accepted request always goes to decode next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DECODE)
    else $error("accepted request not decoded");

  // the alu only answers while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_WAIT)
    else $error("alu done outside of wait");

  // a new result only appears out of a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result valid without commit");

  // a token can not both underflow and overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_under_q && out_over_q))
    else $error("underflow and overflow together");

endmodule

### hdl/pfe_ram.sv
// generic single-write, single-read ram with registered read data
module pfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pfe_alu.sv
// shared iterative alu: one adder serves add, sub, shift-add multiply and restoring divide
module pfe_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfe_pkg::alu_req_t             req_i,
  input  logic [pfe_pkg::DATA_W-1:0]    a_i,
  input  logic [pfe_pkg::DATA_W-1:0]    b_i,
  output pfe_pkg::alu_rsp_t             rsp_o,
  output logic [pfe_pkg::DATA_W-1:0]    result_o
);

  localparam int unsigned W = pfe_pkg::DATA_W;

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_ABSA = 3'd1;
  localparam logic [2:0] A_ABSB = 3'd2;
  localparam logic [2:0] A_MUL  = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_FIX  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [W-1:0]                acc_q, acc_d;
  logic [W-1:0]                opa_q, opa_d;
  logic [W-1:0]                opb_q, opb_d;
  logic [pfe_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic                        neg_q, neg_d;
  logic [W-1:0]                res_q, res_d;
  logic                        done_q, done_d;
  logic                        dz_q, dz_d;

  logic [W-1:0]                add_a, add_b, rem_sh;
  logic                        add_cin;
  logic [W:0]                  sum;

  // operand selection for the one adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    rem_sh  = {acc_q[W-2:0], opa_q[W-1]};
    unique case (state_q)
      A_IDLE: begin
        add_a   = a_i;
        add_b   = (req_i.op == pfe_pkg::ALU_SUB) ? ~b_i : b_i;
        add_cin = (req_i.op == pfe_pkg::ALU_SUB);
      end
      A_ABSA: begin
        add_b   = opa_q[W-1] ? ~opa_q : opa_q;
        add_cin = opa_q[W-1];
      end
      A_ABSB: begin
        add_b   = opb_q[W-1] ? ~opb_q : opb_q;
        add_cin = opb_q[W-1];
      end
      A_MUL: begin
        add_a = acc_q;
        add_b = opb_q[0] ? opa_q : '0;
      end
      A_DIV: begin
        add_a   = rem_sh;
        add_b   = ~opb_q;
        add_cin = 1'b1;
      end
      A_FIX: begin
        add_b   = neg_q ? ~opa_q : opa_q;
        add_cin = neg_q;
      end
      default: ;
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_cin};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    res_d   = res_q;
    dz_d    = dz_q;
    done_d  = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          dz_d  = 1'b0;
          acc_d = '0;
          opa_d = a_i;
          opb_d = b_i;
          cnt_d = pfe_pkg::STEP_W'(pfe_pkg::ALU_STEPS - 1);
          unique case (req_i.op)
            pfe_pkg::ALU_ADD, pfe_pkg::ALU_SUB: begin
              res_d  = sum[W-1:0];
              done_d = 1'b1;
            end
            pfe_pkg::ALU_MUL: begin
              state_d = A_MUL;
            end
            pfe_pkg::ALU_DIV: begin
              if (b_i == '0) begin
                res_d  = '0;
                dz_d   = 1'b1;
                done_d = 1'b1;
              end else begin
                neg_d   = a_i[W-1] ^ b_i[W-1];
                state_d = A_ABSA;
              end
            end
            default: ;
          endcase
        end
      end
      A_ABSA: begin
        opa_d   = sum[W-1:0];
        state_d = A_ABSB;
      end
      A_ABSB: begin
        opb_d   = sum[W-1:0];
        state_d = A_DIV;
      end
      A_MUL: begin
        acc_d = sum[W-1:0];
        opa_d = {opa_q[W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[W-1:1]};
        cnt_d = cnt_q - pfe_pkg::STEP_W'(1);
        if (cnt_q == '0) begin
          res_d   = sum[W-1:0];
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        // carry out means the shifted remainder covers the divisor
        acc_d = sum[W] ? sum[W-1:0] : rem_sh;
        opa_d = {opa_q[W-2:0], sum[W]};
        cnt_d = cnt_q - pfe_pkg::STEP_W'(1);
        if (cnt_q == '0) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        res_d   = sum[W-1:0];
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    neg_q <= neg_d;
    res_q <= res_d;
    dz_q  <= dz_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

endmodule
